>>> rtl/actvc_pkg.sv
package actvc_pkg;

  // Field widths of the channels.
  localparam int ID_W       = 8;
  localparam int CURR_W     = 16;
  localparam int TORQ_W     = 16;
  localparam int RPM_CFG_W  = 6;
  localparam int OUT_W      = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Default window depth for the top level.
  localparam int WINDOW_DEPTH_DEF = 5;

  // Register reset values.
  localparam logic [ID_W-1:0]      MOTOR_ID_RST   = 8'd1;
  localparam logic [RPM_CFG_W-1:0] DEADBAND_RST   = 6'd3;
  localparam logic [RPM_CFG_W-1:0] SATURATION_RST = 6'd55;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MOTOR_ID   = 2'd0,
    REG_DEADBAND   = 2'd1,
    REG_SATURATION = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    OP_TORQUE = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  // rpm = (50*N*T - 324*sum) / (1800*N); in Q.8 this is 32*X / (225*N).
  localparam int TORQ_GAIN_PER_TAP = 50;
  localparam int CURR_GAIN         = 324;
  localparam int DIV_BASE          = 225;
  localparam int DIV_NUM           = 32;
  localparam int DIV_K             = 33;
  localparam int Q_FRAC            = 8;

  // Largest rpm limit the 6-bit registers can give, and a magnitude just above it.
  localparam int MAX_LIM = 2 ** RPM_CFG_W - 1;
  localparam int Q_CAP   = MAX_LIM * (2 ** Q_FRAC) + 1;
  localparam int Q_W     = $clog2(Q_CAP + 1);

  // Register counts = rpm_q8 * 125 / 7328, exact through a rounded-up reciprocal.
  localparam int     REG_NUM = 125;
  localparam int     REG_DEN = 7328;
  localparam int     REG_K   = 27;
  localparam longint REG_M   = ((longint'(REG_NUM) << REG_K) + REG_DEN - 1) / REG_DEN;
  localparam int     REG_M_W = $clog2(REG_M + 1);
  localparam int     REG_R_W = 9;
  localparam int     REG_MAX = 255;

endpackage

>>> rtl/averaged_current_torque_velocity_ctrl.sv
// Averaged-current torque to velocity controller.
//
// Input channel (in_valid/in_ready) carries one beat per item. An item with
// operation set to torque stores the desired torque and gives no result. A
// status sample whose id matches the motor_id register enters a sliding window
// of the last WINDOW_DEPTH current samples; samples of other motors are dropped.
// Once the window is full, each matching sample gives one goal velocity beat
// on the output channel (out_valid/out_ready).
// The configuration channel (cfg_valid/cfg_ready) is always ready and writes
// motor_id, deadband_rpm or saturation_rpm by index; indexes beyond these are
// ignored. Registers should only be written while no result is outstanding.
// Throughput is one item per cycle while the output is not stalled. The window
// sum is kept as a running total, and the error, scaling by reciprocal
// multiplication, deadband and clamp, and the conversion to register counts sit
// in a six-stage pipeline; out_valid is registered behind stages s1 to s5.
// When the receiver stalls, each stage keeps its beat and empty stages still
// fill, so six samples that give results are taken before in_ready falls.
// A synchronous reset restores the register defaults, empties the window and
// the pipeline and clears the held torque.
module averaged_current_torque_velocity_ctrl
  import actvc_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,

  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         operation,
  input  logic [ID_W-1:0]              sample_motor_id,
  input  logic signed [CURR_W-1:0]     current_raw,
  input  logic signed [TORQ_W-1:0]     torque_mnm,

  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [OUT_W-1:0]      goal_velocity_reg,

  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  // Widths and constants that follow from the window depth.
  localparam int     PTR_W    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int     FILL_W   = $clog2(WINDOW_DEPTH + 1);
  localparam int     SUM_W    = CURR_W + $clog2(WINDOW_DEPTH);
  localparam int     X_W      = SUM_W + 11;
  localparam int     DIV_D    = DIV_BASE * WINDOW_DEPTH;
  localparam longint DIV_M    = ((longint'(DIV_NUM) << DIV_K) + DIV_D - 1) / DIV_D;
  localparam int     M_W      = $clog2(DIV_M + 1);
  localparam longint AMAX     = (longint'(Q_CAP) * DIV_D + DIV_NUM - 1) / DIV_NUM;
  localparam int     A_W      = $clog2(AMAX + 1);
  localparam int     P_W      = A_W + M_W;
  localparam int     P2_W     = Q_W + REG_M_W;

  localparam logic signed [X_W-1:0] TORQ_GAIN = X_W'(TORQ_GAIN_PER_TAP * WINDOW_DEPTH);
  localparam logic signed [X_W-1:0] CUR_GAIN  = X_W'(CURR_GAIN);
  localparam logic [X_W-1:0]        AMAX_X    = X_W'(AMAX);

  // Configuration registers.
  logic [ID_W-1:0]      motor_id;
  logic [RPM_CFG_W-1:0] deadband_rpm;
  logic [RPM_CFG_W-1:0] saturation_rpm;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      motor_id       <= MOTOR_ID_RST;
      deadband_rpm   <= DEADBAND_RST;
      saturation_rpm <= SATURATION_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MOTOR_ID:   motor_id       <= cfg_data;
        REG_DEADBAND:   deadband_rpm   <= cfg_data[RPM_CFG_W-1:0];
        REG_SATURATION: saturation_rpm <= cfg_data[RPM_CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Stage handshake. A stage takes a new beat when it is empty or its beat
  // moves on in the same cycle, so bubbles close up behind a stalled output.
  logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy_out;

  assign rdy_out  = !out_valid || out_ready;
  assign rdy5     = !s5_valid || rdy_out;
  assign rdy4     = !s4_valid || rdy5;
  assign rdy3     = !s3_valid || rdy4;
  assign rdy2     = !s2_valid || rdy3;
  assign rdy1     = !s1_valid || rdy2;
  assign in_ready = rdy1;

  // Window state: the taps, the write position, the fill count and the
  // running sum. The oldest tap is at the write position once the window is full.
  logic signed [CURR_W-1:0] window [WINDOW_DEPTH];
  logic [PTR_W-1:0]         wr_pos;
  logic [FILL_W-1:0]        fill;
  logic signed [SUM_W-1:0]  sum;
  logic signed [TORQ_W-1:0] held_torque;

  logic                     in_fire;
  logic                     sample_hit;
  logic                     fill_full;
  logic                     fill_last;
  logic                     gives_result;
  logic signed [SUM_W-1:0]  sum_next;
  logic signed [SUM_W-1:0]  oldest;

  assign in_fire      = in_valid && in_ready;
  assign sample_hit   = (op_t'(operation) == OP_SAMPLE) && (sample_motor_id == motor_id);
  assign fill_full    = (fill == FILL_W'(WINDOW_DEPTH));
  assign fill_last    = (fill == FILL_W'(WINDOW_DEPTH - 1));
  assign gives_result = sample_hit && (fill_full || fill_last);
  assign oldest       = fill_full ? SUM_W'(window[wr_pos]) : '0;
  assign sum_next     = sum + SUM_W'(current_raw) - oldest;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pos      <= '0;
      fill        <= '0;
      sum         <= '0;
      held_torque <= '0;
    end else if (in_fire) begin
      if (op_t'(operation) == OP_TORQUE) begin
        held_torque <= torque_mnm;
      end else if (sample_hit) begin
        sum    <= sum_next;
        wr_pos <= (wr_pos == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : wr_pos + 1'b1;
        if (!fill_full) begin
          fill <= fill + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && sample_hit) begin
      window[wr_pos] <= current_raw;
    end
  end

  // Pipeline payload.
  logic signed [SUM_W-1:0]  s1_sum;
  logic signed [TORQ_W-1:0] s1_torque;
  logic signed [X_W-1:0]    s2_x;
  logic [A_W-1:0]           s3_mag;
  logic                     s3_neg;
  logic [Q_W-1:0]           s4_q;
  logic                     s4_neg;
  logic [Q_W-1:0]           s5_v;
  logic                     s5_neg;

  logic signed [X_W-1:0]    x_next;
  logic [X_W-1:0]           mag_full;
  logic [A_W-1:0]           mag_next;
  logic [P_W-1:0]           prod;
  logic [Q_W-1:0]           db_q;
  logic [Q_W-1:0]           lim_q;
  logic [Q_W-1:0]           v_next;
  logic [P2_W-1:0]          prod2;
  logic [REG_R_W-1:0]       r_raw;
  logic [REG_R_W-1:0]       r_sat;
  logic signed [OUT_W-1:0]  reg_next;

  // Current error scaled so that rpm_q8 = 32 * x / (225 * N).
  assign x_next   = (X_W'(s1_torque) * TORQ_GAIN) - (X_W'(s1_sum) * CUR_GAIN);

  // Magnitudes above the cap land beyond any clamp limit, so they are cut
  // there; this keeps the reciprocal multiplication exact.
  assign mag_full = s2_x[X_W-1] ? X_W'(-s2_x) : X_W'(s2_x);
  assign mag_next = (mag_full > AMAX_X) ? A_W'(AMAX) : mag_full[A_W-1:0];

  assign prod     = P_W'(s3_mag) * P_W'(DIV_M);

  // Deadband first, then the clamp, both on the magnitude.
  assign db_q     = Q_W'({deadband_rpm, Q_FRAC'(0)});
  assign lim_q    = Q_W'({saturation_rpm, Q_FRAC'(0)});
  always_comb begin
    if (s4_q < db_q) begin
      v_next = '0;
    end else if (s4_q > lim_q) begin
      v_next = lim_q;
    end else begin
      v_next = s4_q;
    end
  end

  assign prod2    = P2_W'(s5_v) * P2_W'(REG_M);
  assign r_raw    = prod2[REG_K +: REG_R_W];
  assign r_sat    = (r_raw > REG_R_W'(REG_MAX)) ? REG_R_W'(REG_MAX) : r_raw;
  assign reg_next = s5_neg ? -$signed(OUT_W'(r_sat)) : $signed(OUT_W'(r_sat));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      s5_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1)    s1_valid  <= in_fire && gives_result;
      if (rdy2)    s2_valid  <= s1_valid;
      if (rdy3)    s3_valid  <= s2_valid;
      if (rdy4)    s4_valid  <= s3_valid;
      if (rdy5)    s5_valid  <= s4_valid;
      if (rdy_out) out_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_sum    <= sum_next;
      s1_torque <= held_torque;
    end
    if (rdy2) begin
      s2_x <= x_next;
    end
    if (rdy3) begin
      s3_mag <= mag_next;
      s3_neg <= s2_x[X_W-1];
    end
    if (rdy4) begin
      s4_q   <= prod[DIV_K +: Q_W];
      s4_neg <= s3_neg;
    end
    if (rdy5) begin
      s5_v   <= v_next;
      s5_neg <= s4_neg;
    end
    if (rdy_out) begin
      goal_velocity_reg <= reg_next;
    end
  end

endmodule

>>> rtl/actvc_checker.sv
module actvc_checker
  import actvc_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [OUT_W-1:0]  goal_velocity_reg
);

  // A stalled result beat holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(goal_velocity_reg))
    else $error("result beat changed while stalled");

  // The command stays within the symmetric register range.
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> goal_velocity_reg != -OUT_W'(256))
    else $error("goal velocity outside symmetric range");

  // With the receiver ready, no stage can hold back the input side.
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output is ready");

  // Reset empties the pipeline and leaves the input open.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

endmodule

bind averaged_current_torque_velocity_ctrl actvc_checker u_actvc_checker (.*);
